// ----- rtl/ckl_pkg.sv -----
// ----------------------------------------------------------------------------
// ckl_pkg: shared types and constants for the compacting key list
// Operation and status codes, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package ckl_pkg;

    localparam int DEF_CAPACITY = 256;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 9;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_CHANGE = 2'd2;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SEARCH,
        S_SHIFT,
        S_FINISH
    } t_state;

endpackage

// ----- rtl/ckl_if.sv -----
// ----------------------------------------------------------------------------
// ckl_if: request and response channels of the compacting key list
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ckl_in_if;
    import ckl_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [KEY_W-1:0]   new_key;

    modport source (output valid, output op, output key, output new_key, input ready);
    modport sink   (input valid, input op, input key, input new_key, output ready);
endinterface

interface ckl_out_if;
    import ckl_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output position, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input position, input entry_count,
                    output ready);
endinterface

// ----- rtl/ckl_ram.sv -----
// ----------------------------------------------------------------------------
// ckl_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ckl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ckl_ctrl.sv -----
// ----------------------------------------------------------------------------
// ckl_ctrl: sequencer and shared compare unit of the compacting key list
// Walks the key memory one entry a cycle to search, then, for a delete, to close the gap.
// ----------------------------------------------------------------------------
module ckl_ctrl #(
    parameter int CAPACITY = ckl_pkg::DEF_CAPACITY
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ckl_in_if.sink                      i_req,
    ckl_out_if.source                   o_rsp,
    output logic                        o_we,
    output logic [$clog2(CAPACITY)-1:0] o_waddr,
    output logic [ckl_pkg::KEY_W-1:0]   o_wdata,
    output logic [$clog2(CAPACITY)-1:0] o_raddr,
    input  logic [ckl_pkg::KEY_W-1:0]   i_rdata
);
    import ckl_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    t_state              r_state, n_state;
    logic [OP_W-1:0]     r_op, n_op;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [KEY_W-1:0]    r_new_key, n_new_key;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_pos, n_pos;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [POS_W-1:0]    r_out_pos, n_out_pos;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;

    logic                accept;
    logic                hit;
    logic                at_end;
    logic                out_free;
    logic [CW-1:0]       idx_m1;
    logic [CW-1:0]       idx_m2;
    logic [AW+POS_W-1:0] pos_ext;
    logic [CW+COUNT_W-1:0] count_ext;

    assign accept   = i_req.valid && i_req.ready;
    assign hit      = r_pend && (i_rdata == r_key);
    assign at_end   = (r_idx >= r_count);
    assign out_free = !r_out_valid || o_rsp.ready;
    assign idx_m1   = r_idx - CW'(1);
    assign idx_m2   = r_idx - CW'(2);
    assign pos_ext  = {{POS_W{1'b0}}, r_pos};
    assign count_ext = {{COUNT_W{1'b0}}, r_count};

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.position    = r_out_pos;
    assign o_rsp.entry_count = r_out_count;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = (r_op == OP_APPEND) ? S_FINISH : S_SEARCH;
            end
            S_SEARCH: begin
                if (hit) begin
                    n_state = (r_op == OP_DELETE) ? S_SHIFT : S_FINISH;
                end else if (at_end) begin
                    n_state = S_FINISH;
                end
            end
            S_SHIFT: begin
                if (at_end) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_op         = r_op;
        n_key        = r_key;
        n_new_key    = r_new_key;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_count      = r_count;
        n_pos        = r_pos;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        n_out_count  = r_out_count;
        o_we         = 1'b0;
        o_waddr      = r_count[AW-1:0];
        o_wdata      = r_key;
        o_raddr      = r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op      = i_req.op;
                    n_key     = i_req.key;
                    n_new_key = i_req.new_key;
                end
            end
            S_START: begin
                n_idx  = '0;
                n_pend = 1'b0;
                n_pos  = '0;
                if (r_op == OP_APPEND) begin
                    if (r_count < CAP_C) begin
                        o_we     = 1'b1;
                        n_pos    = r_count[AW-1:0];
                        n_count  = r_count + CW'(1);
                        n_status = ST_DONE;
                    end else begin
                        n_status = ST_FULL;
                    end
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    n_pos    = idx_m1[AW-1:0];
                    n_status = ST_DONE;
                    n_pend   = 1'b0;
                    if (r_op == OP_CHANGE) begin
                        o_we    = 1'b1;
                        o_waddr = idx_m1[AW-1:0];
                        o_wdata = r_new_key;
                    end
                end else if (at_end) begin
                    n_pos    = '0;
                    n_status = ST_MISSING;
                end else begin
                    n_idx  = r_idx + CW'(1);
                    n_pend = 1'b1;
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    o_we    = 1'b1;
                    o_waddr = idx_m2[AW-1:0];
                    o_wdata = i_rdata;
                end
                if (at_end) begin
                    n_count = r_count - CW'(1);
                    n_pend  = 1'b0;
                end else begin
                    n_idx  = r_idx + CW'(1);
                    n_pend = 1'b1;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_pos    = pos_ext[POS_W-1:0];
                    n_out_count  = count_ext[COUNT_W-1:0];
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_new_key    <= n_new_key;
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
        r_out_count  <= n_out_count;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("fill count above capacity");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_START))
        else $error("accepted word did not start the sequencer");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (r_state == S_START || r_state == S_SEARCH || r_state == S_SHIFT))
        else $error("memory write outside an operation");

    a_shift_delete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_op == OP_DELETE))
        else $error("shift pass on an operation other than delete");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ($past(r_state) == S_START || $past(r_state) == S_SHIFT))
        else $error("fill count changed outside append or delete");
`endif

endmodule

// ----- rtl/compacting_key_list_top.sv -----
// ----------------------------------------------------------------------------
// compacting_key_list_top: list of 32-bit keys with linear search
// Append, delete with compaction, change and find over one key memory.
// ----------------------------------------------------------------------------
// Sequence: a start state that writes an append at the fill count, a scan for
//   find, change and delete, a shift pass on delete, then the finish state.
// One word at a time, set by the single read port of the key memory,
//   scanned one entry a cycle up to the match, then past it to shift for a delete.
// Reset clears the fill count and the sequencer; the key memory is not
//   cleared and only entries below the fill count are ever used.
module compacting_key_list_top #(
    parameter int CAPACITY = ckl_pkg::DEF_CAPACITY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ckl_in_if.sink     i_req,
    ckl_out_if.source  o_rsp
);
    import ckl_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic             we;
    logic [AW-1:0]    waddr;
    logic [KEY_W-1:0] wdata;
    logic [AW-1:0]    raddr;
    logic [KEY_W-1:0] rdata;

    ckl_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_raddr (raddr),
        .i_rdata (rdata)
    );

    ckl_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule
